>>> src/lspa_pkg.sv
// ----------------------------------------------------------------------------
// lspa_pkg
// Shared types and constants for the lidar scan packet assembler: register
// indexes, decode constants, packet and point records and store states.
// ----------------------------------------------------------------------------
package lspa_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_MOTOR_RUNNING = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCAN_ACTIVE   = 1'b1;

  // Angle decode: (5*a + 16) / 32, then reduced into one full turn.
  localparam logic [17:0] ANGLE_ROUND = 18'd16;
  localparam logic [12:0] FULL_TURN   = 13'd3600;

  // Distance decode: (d + 20) / 40 clamped to 1200. The divide by 40 is a
  // shift by three and a multiply by the reciprocal of five.
  localparam logic [16:0] DIST_ROUND     = 17'd20;
  localparam logic [16:0] DIST_CLAMP_SUM = 17'd48040;
  localparam logic [15:0] DIV5_RECIP     = 16'd52429;
  localparam logic [10:0] DIST_LIMIT     = 11'd1200;

  // Framed packet, the raw fields needed by the decoder.
  typedef struct packed {
    logic [5:0]  quality;
    logic        new_scan;
    logic [14:0] raw_angle;
    logic [15:0] raw_dist;
  } packet_t;

  // Decoded point as held in the point store.
  typedef struct packed {
    logic [10:0] distance;
    logic [11:0] angle;
    logic [5:0]  quality;
  } point_t;

  // Point store sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_FINISH
  } store_state_t;

endpackage

>>> src/lspa_framer.sv
// ----------------------------------------------------------------------------
// lspa_framer
// Frames received bytes into five-byte packets. Resyncs on a first byte whose
// two low bits differ and drops packets whose check bit is clear.
// ----------------------------------------------------------------------------
module lspa_framer import lspa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  input  logic [7:0] byte_data,
  output logic       pkt_valid,
  output packet_t    pkt
);

  logic [2:0] byte_position;
  logic [7:0] packet_bytes [0:3];

  // Position counter and packet strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 3'd0;
      pkt_valid     <= 1'b0;
    end else begin
      pkt_valid <= 1'b0;
      if (byte_valid) begin
        if (byte_position == 3'd0) begin
          if (byte_data[0] != byte_data[1]) begin
            byte_position <= 3'd1;
          end
        end else if (byte_position < 3'd4) begin
          byte_position <= byte_position + 3'd1;
        end else begin
          byte_position <= 3'd0;
          pkt_valid     <= packet_bytes[1][0];
        end
      end
    end
  end

  // Byte buffer and packet payload. A dropped resync byte lands in slot zero
  // and is overwritten by the next byte taken at position zero.
  always_ff @(posedge clk) begin
    if (byte_valid) begin
      if (byte_position < 3'd4) begin
        packet_bytes[byte_position[1:0]] <= byte_data;
      end else begin
        pkt.quality   <= packet_bytes[0][7:2];
        pkt.new_scan  <= packet_bytes[0][0];
        pkt.raw_angle <= {packet_bytes[2], packet_bytes[1][7:1]};
        pkt.raw_dist  <= {byte_data, packet_bytes[3]};
      end
    end
  end

endmodule

>>> src/lspa_decode.sv
// ----------------------------------------------------------------------------
// lspa_decode
// Two-stage decoder from raw packet fields to quality, angle in tenths of a
// degree and distance in centimeters, all in exact integer arithmetic.
// ----------------------------------------------------------------------------
module lspa_decode import lspa_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    pkt_valid,
  input  packet_t pkt,
  output logic    active,
  output logic    pt_valid,
  output logic    pt_new_scan,
  output point_t  pt
);

  logic [17:0] angle_sum;
  logic [16:0] dist_sum;
  logic        s1_valid;
  logic [5:0]  s1_quality;
  logic        s1_new_scan;
  logic [12:0] s1_angle;
  logic [13:0] s1_eighths;
  logic        s1_over;
  logic [12:0] angle_wrap;
  logic [5:0]  s2_quality;
  logic [11:0] s2_angle;
  logic [29:0] s2_prod;
  logic        s2_over;

  // Stage one: rounding sums; 5*a is formed as 4*a + a.
  assign angle_sum = {1'b0, pkt.raw_angle, 2'b00} + {3'b000, pkt.raw_angle} + ANGLE_ROUND;
  assign dist_sum  = {1'b0, pkt.raw_dist} + DIST_ROUND;

  // Stage two: wrap the angle once and scale the distance by one fifth.
  assign angle_wrap = (s1_angle >= FULL_TURN) ? (s1_angle - FULL_TURN) : s1_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      pt_valid <= 1'b0;
    end else begin
      s1_valid <= pkt_valid;
      pt_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_quality  <= pkt.quality;
    s1_new_scan <= pkt.new_scan;
    s1_angle    <= angle_sum[17:5];
    s1_eighths  <= dist_sum[16:3];
    s1_over     <= (dist_sum >= DIST_CLAMP_SUM);
    s2_quality  <= s1_quality;
    pt_new_scan <= s1_new_scan;
    s2_angle    <= angle_wrap[11:0];
    s2_prod     <= 30'(s1_eighths) * 30'(DIV5_RECIP);
    s2_over     <= s1_over;
  end

  // Final point, with the distance clamped.
  always_comb begin
    pt.quality  = s2_quality;
    pt.angle    = s2_angle;
    pt.distance = s2_over ? DIST_LIMIT : s2_prod[28:18];
  end

  assign active = s1_valid | pt_valid;

endmodule

>>> src/lspa_store.sv
// ----------------------------------------------------------------------------
// lspa_store
// Point store: a single-port-write, registered-read memory of decoded points
// with a sequencer that appends points and delivers a stored scan as a run.
// ----------------------------------------------------------------------------
module lspa_store import lspa_pkg::*; #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   pt_valid,
  input  logic   pt_new_scan,
  input  point_t pt,
  input  logic   out_stall,
  output logic   out_valid,
  output point_t out_point,
  output logic   out_last,
  output logic   idle
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  store_state_t  state;
  store_state_t  state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] rd_idx_next;
  logic          rd_en;
  logic          rd_pending;
  logic          rd_last;
  logic          read_last;
  point_t        rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  point_t        wr_data;
  logic          pend_load;
  point_t        pend_point;
  point_t        mem [0:MAX_POINTS-1];

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      rd_idx     <= '0;
      rd_pending <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      rd_idx     <= rd_idx_next;
      rd_pending <= rd_en;
    end
  end

  assign read_last = ((rd_idx + CW'(1)) == count);

  // Next state, memory accesses and counters.
  always_comb begin
    state_next  = state;
    count_next  = count;
    rd_idx_next = rd_idx;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = count[AW-1:0];
    wr_data     = pt;
    pend_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (pt_valid) begin
          if (pt_new_scan && (count != '0)) begin
            pend_load   = 1'b1;
            rd_idx_next = '0;
            state_next  = ST_EMIT;
          end else if ((pt.distance != '0) && (count < CW'(MAX_POINTS))) begin
            wr_en      = 1'b1;
            count_next = count + CW'(1);
          end
        end
      end
      ST_EMIT: begin
        // One read in flight; issue only when the output stage will be free.
        if (!rd_pending && (!out_valid || !out_stall)) begin
          rd_en       = 1'b1;
          rd_idx_next = rd_idx + CW'(1);
          if (read_last) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        // The store is empty now; the new-scan point becomes entry zero unless its distance is zero.
        wr_addr    = '0;
        wr_data    = pend_point;
        count_next = '0;
        if (pend_point.distance != '0) begin
          wr_en      = 1'b1;
          count_next = CW'(1);
        end
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Point memory with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx[AW-1:0]];
      rd_last <= read_last;
    end
  end

  // Held new-scan point.
  always_ff @(posedge clk) begin
    if (pend_load) begin
      pend_point <= pt;
    end
  end

  // Output register; a read is issued only when it is empty or being drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_pending) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pending) begin
      out_point <= rd_data;
      out_last  <= rd_last;
    end
  end

  assign idle = (state == ST_IDLE);

endmodule

>>> src/lidar_scan_packet_assembler.sv
// A point passes the framer's packet register and the decoder's stage registers before it is stored.
// Input takes one byte per cycle; after the final byte of a packet whose check bit is
// set, input stalls while the packet is decoded, and longer while a run is delivered.
// A delivered run has one memory read in flight; the next read waits for the last one's data.
// Reset clears control registers, byte position and point count; the point memory and data registers are not cleared.
// ----------------------------------------------------------------------------
// lidar_scan_packet_assembler
// Frames sensor bytes into scan packets, decodes them into points, stores
// them and delivers each finished scan as a run of points.
// ----------------------------------------------------------------------------
module lidar_scan_packet_assembler import lspa_pkg::*; #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic                   cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             rx_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [5:0]             quality,
  output logic [11:0]            angle_tenths,
  output logic [10:0]            distance_cm,
  output logic                   last_of_scan
);

  logic    motor_running;
  logic    scan_active;
  logic    byte_valid;
  logic    pkt_valid;
  packet_t pkt;
  logic    decode_active;
  logic    pt_valid;
  logic    pt_new_scan;
  point_t  pt;
  logic    store_idle;
  point_t  out_point;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      motor_running <= 1'b0;
      scan_active   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MOTOR_RUNNING: motor_running <= cfg_data;
        REG_SCAN_ACTIVE:   scan_active   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input transfers are held off while a packet is decoded or a run is sent.
  assign in_stall   = pkt_valid | decode_active | !store_idle;
  assign byte_valid = in_valid & !in_stall & motor_running & scan_active;

  lspa_framer u_framer (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_data  (rx_byte),
    .pkt_valid  (pkt_valid),
    .pkt        (pkt)
  );

  lspa_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .pkt_valid   (pkt_valid),
    .pkt         (pkt),
    .active      (decode_active),
    .pt_valid    (pt_valid),
    .pt_new_scan (pt_new_scan),
    .pt          (pt)
  );

  lspa_store #(
    .MAX_POINTS (MAX_POINTS)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .pt_valid    (pt_valid),
    .pt_new_scan (pt_new_scan),
    .pt          (pt),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_point   (out_point),
    .out_last    (last_of_scan),
    .idle        (store_idle)
  );

  // Result fields.
  assign quality      = out_point.quality;
  assign angle_tenths = out_point.angle;
  assign distance_cm  = out_point.distance;

endmodule
